// ===== src/mtep_pkg.sv =====
// Shared types, constants and helper functions for the MIDI track event parser.
package mtep_pkg;

	// Record kinds on the output channel
	localparam logic [1:0] KIND_SHORT   = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_EMPTY   = 2'd3;

	// Status byte codes
	localparam logic [7:0] ST_PROGRAM  = 8'hC0;
	localparam logic [7:0] ST_BEND     = 8'hE0;
	localparam logic [7:0] ST_SYSEX    = 8'hF0;
	localparam logic [7:0] ST_SONG_POS = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL = 8'hF3;
	localparam logic [7:0] ST_ESCAPE   = 8'hF7;
	localparam logic [7:0] ST_META     = 8'hFF;
	localparam logic [7:0] ST_DRUM_ON  = 8'h99;

	// Chunk tag of a track chunk, "MTrk"
	localparam logic [7:0] TRACK_TAG [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

	typedef enum logic [3:0] {
		PH_TAG,
		PH_SIZE,
		PH_SKIP,
		PH_DELTA,
		PH_STATUS,
		PH_DATA,
		PH_MTYPE,
		PH_LEN,
		PH_PAYLOAD
	} phase_t;

	// Parser state carried from word to word
	typedef struct packed {
		phase_t      phase;
		logic [1:0]  byte_cnt;
		logic        tag_ok;
		logic [31:0] chunk_left;
		logic [31:0] delta;
		logic [7:0]  run_status;
		logic [7:0]  first_data;
		logic [1:0]  data_left;
		logic [31:0] len_acc;
		logic [31:0] payload_left;
		logic [7:0]  track_cnt;
		logic        drum_seen;
	} state_t;

	// One result record
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  track_index;
		logic [31:0] delta_ticks;
		logic [7:0]  status_byte;
		logic [7:0]  data_first;
		logic [7:0]  data_second;
		logic [31:0] payload_length;
		logic [7:0]  payload_byte;
		logic        last;
		logic        track_end;
		logic        has_drum;
	} res_t;

	// Number of data bytes that follow a status byte
	function automatic logic [1:0] data_len(input logic [7:0] st);
		logic [1:0] n;
		priority if (st < ST_PROGRAM) n = 2'd2;
		else if (st < ST_BEND)        n = 2'd1;
		else if (st < ST_SYSEX)       n = 2'd2;
		else if (st == ST_SONG_POS)   n = 2'd2;
		else if (st == ST_SONG_SEL)   n = 2'd1;
		else                          n = 2'd0;
		return n;
	endfunction

endpackage

// ===== src/mtep_if.sv =====
// Valid/ready channel interfaces for the byte stream and the result records.
interface mtep_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface mtep_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  track_index;
	logic [31:0] delta_ticks;
	logic [7:0]  status_byte;
	logic [7:0]  data_first;
	logic [7:0]  data_second;
	logic [31:0] payload_length;
	logic [7:0]  payload_byte;
	logic        last;
	logic        track_end;
	logic        has_drum;

	modport source (output valid, output kind, output track_index, output delta_ticks,
		output status_byte, output data_first, output data_second,
		output payload_length, output payload_byte, output last,
		output track_end, output has_drum, input ready);
	modport sink (input valid, input kind, input track_index, input delta_ticks,
		input status_byte, input data_first, input data_second,
		input payload_length, input payload_byte, input last,
		input track_end, input has_drum, output ready);
endinterface

// ===== src/midi_track_event_parser.sv =====
// Top level of the MIDI track event parser: parser state register, step logic, result register.
// A record appears on the output in the cycle after the word that completes it is taken.
// Throughput: one word per cycle; the input stalls only while a held record is not taken.
// Every word updates the parser state through one pass of the step logic.
// Reset (arst_n low) clears the parser state to expect a chunk tag and empties the result register.
module midi_track_event_parser
	import mtep_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mtep_in_if.sink    stream,
	mtep_out_if.source records
);

	state_t state_q;
	state_t state_nxt;
	logic   emit;
	res_t   res;
	logic   can_load;
	logic   accept;

	assign stream.ready = can_load;
	assign accept       = stream.valid && can_load;

	mtep_step u_step (
		.cur       (state_q),
		.data_byte (stream.data_byte),
		.nxt       (state_nxt),
		.emit      (emit),
		.res       (res)
	);

	// Advance the parser state on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_TAG;
			state_q.byte_cnt     <= '0;
			state_q.tag_ok       <= 1'b1;
			state_q.chunk_left   <= '0;
			state_q.delta        <= '0;
			state_q.run_status   <= '0;
			state_q.first_data   <= '0;
			state_q.data_left    <= '0;
			state_q.len_acc      <= '0;
			state_q.payload_left <= '0;
			state_q.track_cnt    <= '0;
			state_q.drum_seen    <= 1'b0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	mtep_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.emit     (emit),
		.res_in   (res),
		.can_load (can_load),
		.records  (records)
	);

endmodule

// ===== src/mtep_step.sv =====
// Next-state and result logic for one word of the chunk stream.
module mtep_step
	import mtep_pkg::*;
(
	input  state_t     cur,
	input  logic [7:0] data_byte,
	output state_t     nxt,
	output logic       emit,
	output res_t       res
);

	always_comb begin
		logic [31:0] size_new;
		logic [31:0] chunk_dec;
		logic [31:0] len_new;
		logic [31:0] pay_dec;
		logic [7:0]  st_new;
		logic [1:0]  n;
		logic        have;

		nxt  = cur;
		emit = 1'b0;
		res  = '0;

		size_new  = {cur.chunk_left[23:0], data_byte};
		chunk_dec = (cur.chunk_left != '0) ? cur.chunk_left - 32'd1 : cur.chunk_left;
		len_new   = {cur.len_acc[24:0], data_byte[6:0]};
		pay_dec   = (cur.payload_left != '0) ? cur.payload_left - 32'd1 : cur.payload_left;
		st_new    = data_byte[7] ? data_byte : cur.run_status;
		n         = data_len(st_new);
		have      = 1'b0;

		// Count down the track chunk on every word of a track event
		if (cur.phase == PH_DELTA || cur.phase == PH_STATUS || cur.phase == PH_DATA ||
			cur.phase == PH_MTYPE || cur.phase == PH_LEN || cur.phase == PH_PAYLOAD) begin
			nxt.chunk_left = chunk_dec;
		end

		unique case (cur.phase)
			PH_TAG: begin
				if (data_byte != TRACK_TAG[cur.byte_cnt]) nxt.tag_ok = 1'b0;
				if (cur.byte_cnt == 2'd3) begin
					nxt.byte_cnt   = 2'd0;
					nxt.chunk_left = '0;
					nxt.phase      = PH_SIZE;
				end else begin
					nxt.byte_cnt = cur.byte_cnt + 2'd1;
				end
			end
			PH_SIZE: begin
				nxt.chunk_left = size_new;
				if (cur.byte_cnt != 2'd3) begin
					nxt.byte_cnt = cur.byte_cnt + 2'd1;
				end else begin
					nxt.byte_cnt = 2'd0;
					if (!cur.tag_ok) begin
						nxt.tag_ok = 1'b1;
						nxt.phase  = (size_new != '0) ? PH_SKIP : PH_TAG;
					end else begin
						nxt.drum_seen = 1'b0;
						nxt.delta     = '0;
						if (size_new == '0) begin
							// empty track: one record, closed below
							emit            = 1'b1;
							res.kind        = KIND_EMPTY;
							res.track_index = cur.track_cnt;
							res.last        = 1'b1;
						end else begin
							nxt.phase = PH_DELTA;
						end
					end
				end
			end
			PH_SKIP: begin
				nxt.chunk_left = chunk_dec;
				if (chunk_dec == '0) nxt.phase = PH_TAG;
			end
			PH_DELTA: begin
				nxt.delta = {cur.delta[24:0], data_byte[6:0]};
				if (!data_byte[7]) nxt.phase = PH_STATUS;
			end
			PH_STATUS: begin
				// apply running status; a data byte here is the first data byte
				nxt.run_status = st_new;
				if (!data_byte[7] && n != 2'd0) begin
					nxt.first_data = data_byte;
					have           = 1'b1;
					n              = n - 2'd1;
				end
				if (st_new == ST_DRUM_ON) nxt.drum_seen = 1'b1;
				if (st_new == ST_SYSEX || st_new == ST_ESCAPE || st_new == ST_META) begin
					nxt.first_data = '0;
					nxt.len_acc    = '0;
					nxt.phase      = (st_new == ST_META) ? PH_MTYPE : PH_LEN;
				end else if (n == 2'd0) begin
					emit            = 1'b1;
					res.kind        = KIND_SHORT;
					res.track_index = cur.track_cnt;
					res.delta_ticks = cur.delta;
					res.status_byte = st_new;
					res.data_first  = have ? data_byte : 8'd0;
					res.last        = 1'b1;
				end else begin
					nxt.data_left = n;
					nxt.phase     = PH_DATA;
				end
			end
			PH_DATA: begin
				if (data_len(cur.run_status) == 2'd2 && cur.data_left >= 2'd2) begin
					nxt.first_data = data_byte;
					nxt.data_left  = 2'd1;
				end else begin
					nxt.data_left   = 2'd0;
					emit            = 1'b1;
					res.kind        = KIND_SHORT;
					res.track_index = cur.track_cnt;
					res.delta_ticks = cur.delta;
					res.status_byte = cur.run_status;
					res.last        = 1'b1;
					if (data_len(cur.run_status) == 2'd2) begin
						res.data_first  = cur.first_data;
						res.data_second = data_byte;
					end else begin
						res.data_first = data_byte;
					end
				end
			end
			PH_MTYPE: begin
				nxt.first_data = data_byte;
				nxt.phase      = PH_LEN;
			end
			PH_LEN: begin
				nxt.len_acc = len_new;
				if (!data_byte[7]) begin
					nxt.payload_left   = len_new;
					if (len_new != '0) nxt.phase = PH_PAYLOAD;
					emit               = 1'b1;
					res.kind           = KIND_HEADER;
					res.track_index    = cur.track_cnt;
					res.delta_ticks    = cur.delta;
					res.status_byte    = cur.run_status;
					res.data_first     = cur.first_data;
					res.payload_length = len_new;
					res.last           = (len_new == '0);
				end
			end
			PH_PAYLOAD: begin
				nxt.payload_left = pay_dec;
				emit             = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.track_index  = cur.track_cnt;
				res.delta_ticks  = cur.delta;
				res.status_byte  = cur.run_status;
				res.data_first   = cur.first_data;
				res.payload_byte = data_byte;
				res.last         = (pay_dec == '0);
			end
			default: begin
				nxt.phase    = PH_TAG;
				nxt.byte_cnt = 2'd0;
			end
		endcase

		// Close the event: end the track when the chunk is used up
		if (emit && res.last) begin
			if (nxt.chunk_left == '0) begin
				res.track_end = 1'b1;
				res.has_drum  = nxt.drum_seen;
				nxt.track_cnt = cur.track_cnt + 8'd1;
				nxt.drum_seen = 1'b0;
				nxt.phase     = PH_TAG;
				nxt.byte_cnt  = 2'd0;
			end else begin
				nxt.phase = PH_DELTA;
				nxt.delta = '0;
			end
		end
	end

endmodule

// ===== src/mtep_out_reg.sv =====
// Result register that holds one record until the output side takes it.
module mtep_out_reg
	import mtep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        emit,
	input  res_t        res_in,
	output logic        can_load,
	mtep_out_if.source  records
);

	logic valid_q;
	res_t res_q;

	// Load when empty or when the held record leaves this cycle
	assign can_load = !valid_q || records.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= emit;
		end else if (records.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the record payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q <= res_in;
		end
	end

	assign records.valid          = valid_q;
	assign records.kind           = res_q.kind;
	assign records.track_index    = res_q.track_index;
	assign records.delta_ticks    = res_q.delta_ticks;
	assign records.status_byte    = res_q.status_byte;
	assign records.data_first     = res_q.data_first;
	assign records.data_second    = res_q.data_second;
	assign records.payload_length = res_q.payload_length;
	assign records.payload_byte   = res_q.payload_byte;
	assign records.last           = res_q.last;
	assign records.track_end      = res_q.track_end;
	assign records.has_drum       = res_q.has_drum;

endmodule

// ===== src/mtep_checker.sv =====
// Port-level checks for the MIDI track event parser, bound to the top level.
module mtep_checker
	import mtep_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	mtep_in_if.sink    stream,
	mtep_out_if.source records
);

	logic       seen_q;
	logic [7:0] exp_idx_q;

	// Track the index the next record must carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			exp_idx_q <= '0;
		end else if (records.valid && records.ready) begin
			seen_q    <= 1'b1;
			exp_idx_q <= records.track_index + {7'd0, records.track_end};
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && !records.ready |=> records.valid)
		else $error("record dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && !records.ready |=> $stable(records.kind) &&
		$stable(records.delta_ticks) && $stable(records.payload_length) &&
		$stable(records.last) && $stable(records.track_end))
		else $error("record changed while stalled");

	a_no_take_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && !records.ready |-> !stream.ready)
		else $error("word taken while a record is stalled");

	a_track_index: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && seen_q |-> records.track_index == exp_idx_q)
		else $error("track index out of sequence");

	a_empty_track: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && records.kind == KIND_EMPTY |->
		records.last && records.track_end && !records.has_drum &&
		records.delta_ticks == '0)
		else $error("malformed empty track record");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.stream  (stream),
	.records (records)
);

// ===== sim/tb_midi_track_event_parser.sv =====
// Testbench for the MIDI track event parser: byte stimulus, shadow parser and record checks.
`timescale 1ns / 100ps

module tb_midi_track_event_parser;
	import mtep_pkg::*;

	typedef logic [7:0] word_q_t [$];

	localparam logic [31:0] MTRK_TAG = {TRACK_TAG[0], TRACK_TAG[1], TRACK_TAG[2], TRACK_TAG[3]};
	localparam logic [31:0] MTHD_TAG = 32'h4D54_6864;
	localparam logic [7:0]  ST_TUNE_REQ = 8'hF6;
	localparam logic [7:0]  ST_SYS_FIRST = 8'hF1;
	localparam logic [7:0]  ST_VOICE_FIRST = 8'h80;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_WORDS = 100;

	logic clk = 1'b0;
	logic arst_n;

	mtep_in_if  stream_if ();
	mtep_out_if records_if ();

	midi_track_event_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_if),
		.records (records_if)
	);

	always #5 clk = ~clk;

	// Shadow parser state
	phase_t      ps_phase;
	logic [2:0]  ps_count;
	logic        ps_tag_ok;
	logic [31:0] ps_chunk_left;
	logic [31:0] ps_delta;
	logic [7:0]  ps_status;
	logic [7:0]  ps_first;
	logic [1:0]  ps_data_left;
	logic [31:0] ps_len;
	logic [31:0] ps_payload_left;
	logic [7:0]  ps_track;
	logic        ps_drum;

	res_t pending_records [$];

	int unsigned words_sent;
	int unsigned parsed_words;
	int unsigned records_checked;
	int unsigned kind_count [4];
	int unsigned tracks_closed;
	int unsigned errors;

	bit          idle_on;
	bit          long_hold_req;
	int unsigned rx_stall;
	logic [7:0]  gen_status;

	// Number of data bytes a status byte calls for
	function automatic int unsigned status_data_count(input logic [7:0] st);
		if (st >= ST_SYSEX) begin
			if (st == ST_SONG_POS)
				return 2;
			if (st == ST_SONG_SEL)
				return 1;
			return 0;
		end
		if (st >= ST_PROGRAM && st < ST_BEND)
			return 1;
		return 2;
	endfunction

	function automatic void clear_parser();
		ps_phase = PH_TAG;
		ps_count = '0;
		ps_tag_ok = 1'b1;
		ps_chunk_left = '0;
		ps_delta = '0;
		ps_status = '0;
		ps_first = '0;
		ps_data_left = '0;
		ps_len = '0;
		ps_payload_left = '0;
		ps_track = '0;
		ps_drum = 1'b0;
	endfunction

	function automatic void close_track();
		ps_track = ps_track + 8'd1;
		ps_drum = 1'b0;
		ps_phase = PH_TAG;
		ps_count = '0;
		tracks_closed++;
	endfunction

	// Queue one record; the last record of an event either ends the track or rearms the delta
	function automatic void post_record(input logic [1:0] kind, input logic [7:0] d1,
			input logic [7:0] d2, input logic [31:0] plen, input logic [7:0] pbyte,
			input logic last);
		res_t r;
		r.kind = kind;
		r.track_index = ps_track;
		r.delta_ticks = ps_delta;
		r.status_byte = ps_status;
		r.data_first = d1;
		r.data_second = d2;
		r.payload_length = plen;
		r.payload_byte = pbyte;
		r.last = last;
		r.track_end = 1'b0;
		r.has_drum = 1'b0;
		if (last) begin
			if (ps_chunk_left == 0) begin
				r.track_end = 1'b1;
				r.has_drum = ps_drum;
				close_track();
			end else begin
				ps_phase = PH_DELTA;
				ps_delta = '0;
			end
		end
		pending_records.push_back(r);
	endfunction

	// Advance the shadow parser by one accepted word
	function automatic void parse_byte(input logic [7:0] b);
		res_t        empty_rec;
		int unsigned n;
		logic        have;
		case (ps_phase)
			PH_TAG: begin
				if (b != TRACK_TAG[ps_count[1:0]])
					ps_tag_ok = 1'b0;
				ps_count = ps_count + 3'd1;
				if (ps_count >= 3'd4) begin
					ps_count = '0;
					ps_chunk_left = '0;
					ps_phase = PH_SIZE;
				end
			end
			PH_SIZE: begin
				ps_chunk_left = {ps_chunk_left[23:0], b};
				ps_count = ps_count + 3'd1;
				if (ps_count == 3'd4) begin
					ps_count = '0;
					if (!ps_tag_ok) begin
						ps_tag_ok = 1'b1;
						if (ps_chunk_left != 0)
							ps_phase = PH_SKIP;
						else
							ps_phase = PH_TAG;
					end else begin
						ps_drum = 1'b0;
						ps_delta = '0;
						if (ps_chunk_left == 0) begin
							empty_rec = '0;
							empty_rec.kind = KIND_EMPTY;
							empty_rec.track_index = ps_track;
							empty_rec.last = 1'b1;
							empty_rec.track_end = 1'b1;
							pending_records.push_back(empty_rec);
							close_track();
						end else begin
							ps_phase = PH_DELTA;
						end
					end
				end
			end
			PH_SKIP: begin
				if (ps_chunk_left != 0)
					ps_chunk_left--;
				if (ps_chunk_left == 0)
					ps_phase = PH_TAG;
			end
			PH_DELTA, PH_STATUS, PH_DATA, PH_MTYPE, PH_LEN, PH_PAYLOAD: begin
				// Track bytes count down the chunk, saturating at zero
				if (ps_chunk_left != 0)
					ps_chunk_left--;
				case (ps_phase)
					PH_DELTA: begin
						ps_delta = {ps_delta[24:0], b[6:0]};
						if (!b[7])
							ps_phase = PH_STATUS;
					end
					PH_STATUS: begin
						have = 1'b0;
						if (b[7]) begin
							ps_status = b;
							n = status_data_count(b);
						end else begin
							n = status_data_count(ps_status);
							if (n > 0) begin
								ps_first = b;
								have = 1'b1;
								n--;
							end
						end
						if (ps_status == ST_DRUM_ON)
							ps_drum = 1'b1;
						if (ps_status == ST_SYSEX || ps_status == ST_ESCAPE
								|| ps_status == ST_META) begin
							ps_first = '0;
							ps_len = '0;
							if (ps_status == ST_META)
								ps_phase = PH_MTYPE;
							else
								ps_phase = PH_LEN;
						end else if (n == 0) begin
							post_record(KIND_SHORT, have ? ps_first : 8'h00, 8'h00, '0,
								8'h00, 1'b1);
						end else begin
							ps_data_left = n[1:0];
							ps_phase = PH_DATA;
						end
					end
					PH_DATA: begin
						if (status_data_count(ps_status) == 2 && ps_data_left >= 2'd2) begin
							ps_first = b;
							ps_data_left = 2'd1;
						end else begin
							ps_data_left = '0;
							if (status_data_count(ps_status) == 2)
								post_record(KIND_SHORT, ps_first, b, '0, 8'h00, 1'b1);
							else
								post_record(KIND_SHORT, b, 8'h00, '0, 8'h00, 1'b1);
						end
					end
					PH_MTYPE: begin
						ps_first = b;
						ps_phase = PH_LEN;
					end
					PH_LEN: begin
						ps_len = {ps_len[24:0], b[6:0]};
						if (!b[7]) begin
							ps_payload_left = ps_len;
							if (ps_len != 0)
								ps_phase = PH_PAYLOAD;
							post_record(KIND_HEADER, ps_first, 8'h00, ps_len, 8'h00,
								ps_len == 0);
						end
					end
					default: begin
						if (ps_payload_left != 0)
							ps_payload_left--;
						post_record(KIND_PAYLOAD, ps_first, 8'h00, '0, b,
							ps_payload_left == 0);
					end
				endcase
			end
			default: begin
				ps_phase = PH_TAG;
				ps_count = '0;
			end
		endcase
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one word and advance the shadow parser once it is taken
	task automatic send_word(input logic [7:0] b);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			stream_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.data_byte <= b;
		@(posedge clk);
		while (stream_if.ready !== 1'b1)
			@(posedge clk);
		if (ps_phase >= PH_DELTA)
			parsed_words++;
		words_sent++;
		parse_byte(b);
	endtask

	task automatic send_chunk(input logic [31:0] tag, input logic [31:0] chunk_len,
			input word_q_t body);
		for (int i = 3; i >= 0; i--)
			send_word(tag[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			send_word(chunk_len[8*i +: 8]);
		foreach (body[i])
			send_word(body[i]);
	endtask

	// Finish whatever event is still open so the next word starts a chunk tag
	task automatic settle_track();
		while (ps_phase != PH_TAG) begin
			case (ps_phase)
				PH_STATUS: send_word(ST_TUNE_REQ);
				PH_MTYPE:  send_word(8'h01);
				default:   send_word(8'h00);
			endcase
		end
	endtask

	function automatic void put_vlq(ref word_q_t q, input logic [31:0] v);
		logic [6:0] grp [5];
		int         n;
		n = 0;
		do begin
			grp[n] = v[6:0];
			n++;
			v = v >> 7;
		end while (v != 0 && n < 5);
		for (int i = n - 1; i >= 0; i--)
			q.push_back({i != 0, grp[i]});
	endfunction

	function automatic void add_payload(ref word_q_t q);
		int unsigned plen;
		if ($urandom_range(0, 19) == 0)
			plen = $urandom_range(5, 140);
		else
			plen = $urandom_range(0, 4);
		put_vlq(q, plen);
		repeat (plen) q.push_back(8'($urandom));
	endfunction

	// Append one event: delta time, then a status (or running status) and its bytes
	function automatic void add_event(ref word_q_t q, ref bit clean, input bit allow_noise);
		logic [7:0]  st;
		int unsigned r;
		int unsigned ndata;
		r = $urandom_range(0, 9);
		if (r < 5)
			put_vlq(q, 0);
		else if (r < 8)
			put_vlq(q, $urandom_range(1, 127));
		else if (r < 9)
			put_vlq(q, $urandom_range(128, 2097151));
		else
			put_vlq(q, $urandom & 32'h0FFF_FFFF);
		r = $urandom_range(0, 99);
		if (r < 25 && gen_status != 0) begin
			// running status: a data byte first, dropped when the status takes none
			ndata = status_data_count(gen_status);
			if (gen_status == ST_META || gen_status == ST_SYSEX || gen_status == ST_ESCAPE) begin
				q.push_back(8'($urandom_range(0, 127)));
				if (gen_status == ST_META)
					q.push_back(8'($urandom));
				add_payload(q);
			end else if (ndata == 0) begin
				q.push_back(8'($urandom_range(0, 127)));
			end else begin
				repeat (ndata) q.push_back(8'($urandom_range(0, 127)));
			end
		end else if (r < 60) begin
			if ($urandom_range(0, 9) == 0)
				st = ST_DRUM_ON;
			else
				st = ST_VOICE_FIRST + 8'($urandom_range(0, 111));
			q.push_back(st);
			gen_status = st;
			repeat (status_data_count(st)) q.push_back(8'($urandom_range(0, 127)));
		end else if (r < 72) begin
			q.push_back(ST_META);
			gen_status = ST_META;
			q.push_back(8'($urandom));
			add_payload(q);
		end else if (r < 80) begin
			st = $urandom_range(0, 1) ? ST_SYSEX : ST_ESCAPE;
			q.push_back(st);
			gen_status = st;
			add_payload(q);
		end else if (r < 92 || !allow_noise) begin
			do
				st = ST_SYS_FIRST + 8'($urandom_range(0, 13));
			while (st == ST_ESCAPE);
			q.push_back(st);
			gen_status = st;
			repeat (status_data_count(st)) q.push_back(8'($urandom_range(0, 127)));
		end else begin
			q.push_back(8'($urandom));
			clean = 1'b0;
		end
	endfunction

	// Send a track of random events; a clean one may get a size that cuts into its last event.
	// A stray byte goes only into the last event, so the parse can always be closed quickly.
	task automatic send_random_track(input int unsigned events, input bit allow_noise,
			input bit allow_overrun);
		word_q_t     body;
		bit          clean;
		int unsigned last_start;
		int unsigned chunk_len;
		gen_status = ps_status;
		clean = 1'b1;
		last_start = 0;
		for (int unsigned e = 0; e < events; e++) begin
			last_start = body.size();
			add_event(body, clean, allow_noise && (e == events - 1));
		end
		chunk_len = body.size();
		if (clean && allow_overrun && $urandom_range(0, 3) == 0)
			chunk_len = last_start + $urandom_range(1, body.size() - last_start);
		send_chunk(MTRK_TAG, chunk_len, body);
		settle_track();
	endtask

	task automatic send_skip_chunk();
		word_q_t     body;
		logic [31:0] tag;
		int unsigned chunk_len;
		if ($urandom_range(0, 1))
			tag = MTRK_TAG ^ (32'd1 << $urandom_range(0, 31));
		else
			tag = $urandom;
		if (tag == MTRK_TAG)
			tag = tag ^ 32'd1;
		chunk_len = $urandom_range(0, 10);
		repeat (chunk_len) body.push_back(8'($urandom));
		send_chunk(tag, chunk_len, body);
	endtask

	// Skipped chunks, empty and not, then an empty track chunk
	task automatic test_chunk_framing();
		word_q_t body;
		body = {};
		send_chunk(MTHD_TAG, 0, body);
		body = {ST_META, 8'h00};
		send_chunk(MTHD_TAG, 2, body);
		body = {};
		send_chunk(MTRK_TAG, 0, body);
	endtask

	// Every status class, running status, dropped data bytes, delta and length wrap
	task automatic test_status_decoding();
		word_q_t body;
		body = {
			8'h00, 8'h3C, 8'h7F,                       // data before any status
			8'h00, ST_DRUM_ON, 8'h24, 8'h7F,
			8'h00, 8'h40, 8'h00,                       // running status
			8'h81, 8'h00, 8'hC5, 8'h7F,
			8'h00, ST_BEND, 8'h00, 8'h7F,
			8'h00, ST_SONG_POS, 8'h7F, 8'h00,
			8'h00, ST_SONG_SEL, 8'h05,
			8'h00, ST_SYS_FIRST,
			8'h00, 8'h12,                              // dropped after a no-data status
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,         // delta wraps to all ones
			ST_META, 8'h2F, 8'h00,
			8'h00, ST_META, 8'h01, 8'h02, 8'h41, 8'hFF,
			8'h00, ST_SYSEX, 8'h81, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01, ST_ESCAPE,
			8'h00, ST_ESCAPE, 8'h00,
			8'h00, 8'h22, 8'h00                        // empty payload ends the track
		};
		send_chunk(MTRK_TAG, body.size(), body);
		settle_track();
	endtask

	// Size runs out inside a meta event; the track ends on its last payload word
	task automatic test_overrun();
		word_q_t body;
		body = {8'h00, ST_DRUM_ON, 8'h30, 8'h40, 8'h00, ST_META, 8'h03, 8'h03,
			8'h41, 8'h42, 8'h43};
		send_chunk(MTRK_TAG, 5, body);
		settle_track();
	endtask

	// Receiver holds off while the sender keeps offering words
	task automatic test_output_backpressure();
		idle_on = 1'b0;
		long_hold_req = 1'b1;
		send_random_track(16, 1'b0, 1'b0);
		idle_on = 1'b1;
	endtask

	// Sender pauses until every queued record has been taken
	task automatic test_drain_pause();
		send_random_track(6, 1'b0, 1'b0);
		stream_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
		send_random_track(6, 1'b0, 1'b1);
	endtask

	task automatic test_random_stream();
		int unsigned start_words;
		int unsigned r;
		start_words = parsed_words;
		while (parsed_words - start_words < RANDOM_WORDS) begin
			idle_on = ($urandom_range(0, 5) != 0);
			r = $urandom_range(0, 99);
			if (r < 75)
				send_random_track($urandom_range(1, 10), $urandom_range(0, 4) == 0, 1'b1);
			else if (r < 90)
				send_skip_chunk();
			else
				test_chunk_framing();
		end
		idle_on = 1'b1;
	endtask

	// A track that claims the largest size, so it never closes
	task automatic test_open_track();
		word_q_t body;
		bit      clean;
		clean = 1'b1;
		gen_status = ps_status;
		repeat (6) add_event(body, clean, 1'b0);
		send_chunk(MTRK_TAG, 32'hFFFF_FFFF, body);
	endtask

	// Receiver side: random stalls plus one long hold on request
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			rx_stall = HOLD_CYCLES;
		end
		if (rx_stall != 0) begin
			rx_stall--;
			records_if.ready <= 1'b0;
		end else begin
			records_if.ready <= 1'b1;
			rx_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		end
	end

	function automatic bit field_differs(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Compare each taken record with the oldest prediction
	always @(posedge clk) begin
		res_t want;
		bit   bad;
		if (records_if.valid === 1'b1 && records_if.ready === 1'b1) begin
			if (pending_records.size() == 0) begin
				$display("%0t: record with none expected, expected nothing, got kind %0d",
					$time, records_if.kind);
				errors++;
			end else begin
				want = pending_records.pop_front();
				bad = 1'b0;
				bad |= field_differs("kind", want.kind, records_if.kind);
				bad |= field_differs("track_index", want.track_index, records_if.track_index);
				bad |= field_differs("delta_ticks", want.delta_ticks, records_if.delta_ticks);
				bad |= field_differs("status_byte", want.status_byte, records_if.status_byte);
				bad |= field_differs("data_first", want.data_first, records_if.data_first);
				bad |= field_differs("data_second", want.data_second, records_if.data_second);
				bad |= field_differs("payload_length", want.payload_length,
					records_if.payload_length);
				bad |= field_differs("payload_byte", want.payload_byte,
					records_if.payload_byte);
				bad |= field_differs("last", want.last, records_if.last);
				bad |= field_differs("track_end", want.track_end, records_if.track_end);
				bad |= field_differs("has_drum", want.has_drum, records_if.has_drum);
				if (bad)
					errors++;
				records_checked++;
				kind_count[want.kind]++;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("[midi_track_event_parser] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.data_byte = 8'h00;
		records_if.ready = 1'b0;
		idle_on = 1'b1;
		long_hold_req = 1'b0;
		rx_stall = 0;
		gen_status = '0;
		clear_parser();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_chunk_framing();
		test_status_decoding();
		test_overrun();
		test_output_backpressure();
		test_drain_pause();
		test_random_stream();
		test_open_track();

		// Drain: wait for every predicted record, then stay quiet before the summary
		stream_if.valid <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words (%0d inside tracks), closed %0d tracks.",
			words_sent, parsed_words, tracks_closed);
		$display("Checked %0d records: %0d short, %0d header, %0d payload, %0d empty track.",
			records_checked, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		if (errors == 0)
			$display("[midi_track_event_parser] OK");
		else
			$display("[midi_track_event_parser] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/mtep_pkg.sv
src/mtep_if.sv
src/mtep_step.sv
src/mtep_out_reg.sv
src/midi_track_event_parser.sv
src/mtep_checker.sv
sim/tb_midi_track_event_parser.sv
